@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("check failed");
`define CHK_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("check failed");
`endif

@@ sv/bcd_pkg.sv @@
// Package for the block cache directory: sizes, codes, beat types.
// No dependencies.
package bcd_pkg;
   localparam int Slots = 64;
   localparam int SlotW = 6;
   localparam int CntW = 7;
   localparam int BlockBits = 12;
   localparam logic [3:0] RefLimit = 4'd15;

   typedef enum logic [1:0] {
      FN_GET = 2'd0, FN_RELEASE = 2'd1, FN_WB_TAKE = 2'd2, FN_WB_DONE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_HIT = 3'd0, ST_MISS = 3'd1, ST_BADPOS = 3'd2, ST_BUSY = 3'd3,
      ST_NOVICTIM = 3'd4, ST_WBTAKEN = 3'd5, ST_NONEDIRTY = 3'd6, ST_BADREL = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_VICTIM, S_WRITE, S_COUNT, S_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] block_pos;
      logic [5:0]  entry_index;
      logic        mark_dirty;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  result_slot;
      logic [63:0] result_pos;
      logic        all_clean;
      logic [6:0]  free_count;
      logic [6:0]  dirty_count;
   } rsp_type;

   // per-slot marks: valid, ref count, lock, dirty
   typedef struct packed {
      logic       valid;
      logic [3:0] refs;
      logic       lock;
      logic       dirty;
   } mark_type;
endpackage

@@ sv/block_cache_directory.sv @@
// Block cache directory top level: tag and mark memories with a sequencer.
// Depends on bcd_pkg.
//
//  channel | ports                            | dir
//  req     | req_valid req_stall req_data     | in
//  rsp     | rsp_valid rsp_stall rsp_data     | out
//
// After reset a clearing pass over all slots zeroes the mark memory; no beat is taken then.
// A bad position beat is accepted and goes straight to output. Any other beat is accepted,
// then walks over all slots (one read per cycle), decides, walks for a victim on a miss
// when any slot is free, writes when marks change, recounts over all slots and outputs.
// A stalled result holds the sequencer in its output state; beats are taken only in idle.
module block_cache_directory (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  bcd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output bcd_pkg::rsp_type rsp_data
);
   import bcd_pkg::*;

   logic [63:0] tag_mem [Slots];
   mark_type    mark_mem [Slots];
   logic [63:0] tag_rd_ff;
   mark_type    mark_rd_ff;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [SlotW:0] cnt_ff, cnt_in;     // walk counter, top bit = done
   logic [SlotW-1:0] rd_addr_ff, rd_addr_in;
   logic [SlotW-1:0] hand_ff, hand_in;
   logic found_ff, found_in;           // hit, writeback candidate, entry or victim found
   logic [SlotW-1:0] fslot_ff, fslot_in;
   mark_type fmark_ff, fmark_in;
   logic [63:0] fpos_ff, fpos_in;
   logic [CntW-1:0] ev_ff, ev_in, dt_ff, dt_in;
   logic [CntW-1:0] evn_ff, evn_in, dtn_ff, dtn_in;
   logic [2:0] st_ff, st_in;
   logic [SlotW-1:0] rslot_ff, rslot_in;
   logic [63:0] rpos_ff, rpos_in;
   logic wr_en;
   logic [SlotW-1:0] wr_addr;
   mark_type wr_mark;
   logic wr_tag;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic rd_valid_ff;
   logic [SlotW-1:0] rd_slot_ff;
   logic evictable;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mark_mem[wr_addr] <= wr_mark;
         if (wr_tag) tag_mem[wr_addr] <= req_ff.block_pos;
      end
      // marks are write-first on a same-slot read; tags are not
      mark_rd_ff <= (wr_en && wr_addr == rd_addr_in) ? wr_mark : mark_mem[rd_addr_in];
      tag_rd_ff  <= tag_mem[rd_addr_in];
   end

   assign evictable = (mark_rd_ff.refs == 4'd0) && !mark_rd_ff.dirty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         hand_ff <= '0;
         ev_ff <= CntW'(Slots);
         dt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         hand_ff <= hand_in;
         ev_ff <= ev_in;
         dt_ff <= dt_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff <= (state_in == S_SCAN || state_in == S_VICTIM || state_in == S_COUNT)
                        && !cnt_in[SlotW];
      end
      req_ff <= req_in;
      rd_addr_ff <= rd_addr_in;
      rd_slot_ff <= rd_addr_in;
      found_ff <= found_in;
      fslot_ff <= fslot_in;
      fmark_ff <= fmark_in;
      fpos_ff <= fpos_in;
      evn_ff <= evn_in;
      dtn_ff <= dtn_in;
      st_ff <= st_in;
      rslot_ff <= rslot_in;
      rpos_ff <= rpos_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      cnt_in = cnt_ff;
      rd_addr_in = rd_addr_ff;
      hand_in = hand_ff;
      found_in = found_ff;
      fslot_in = fslot_ff;
      fmark_in = fmark_ff;
      fpos_in = fpos_ff;
      ev_in = ev_ff;
      dt_in = dt_ff;
      evn_in = evn_ff;
      dtn_in = dtn_ff;
      st_in = st_ff;
      rslot_in = rslot_ff;
      rpos_in = rpos_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en = 1'b0;
      wr_addr = cnt_ff[SlotW-1:0];
      wr_mark = '0;
      wr_tag = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (SlotW+1)'(Slots - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in = req_data;
               found_in = 1'b0;
               fslot_in = req_data.entry_index;
               fpos_in = '0;
               cnt_in = '0;
               rd_addr_in = (req_data.func == FN_RELEASE || req_data.func == FN_WB_DONE)
                            ? req_data.entry_index : '0;
               state_in = S_SCAN;
               if (req_data.func == FN_GET && req_data.block_pos[BlockBits-1:0] != '0) begin
                  st_in = ST_BADPOS;
                  rslot_in = '0;
                  rpos_in = '0;
                  evn_in = ev_ff;
                  dtn_in = dt_ff;
                  state_in = S_OUT;
               end
            end
         end
         S_SCAN: begin
            // one read per cycle; the result is registered and shows in the cycle after the address
            if (!cnt_ff[SlotW]) begin
               cnt_in = cnt_ff + 1'b1;
               rd_addr_in = rd_addr_ff + 1'b1;
            end
            if (rd_valid_ff && !found_ff) begin
               case (func_type'(req_ff.func))
                  FN_GET: if (mark_rd_ff.valid && tag_rd_ff == req_ff.block_pos) begin
                     found_in = 1'b1; fslot_in = rd_slot_ff; fmark_in = mark_rd_ff;
                  end
                  FN_WB_TAKE: if (mark_rd_ff.dirty && mark_rd_ff.refs == 4'd0) begin
                     found_in = 1'b1; fslot_in = rd_slot_ff; fmark_in = mark_rd_ff;
                     fpos_in = tag_rd_ff;
                  end
                  default: if (rd_slot_ff == req_ff.entry_index) begin
                     found_in = 1'b1; fmark_in = mark_rd_ff;
                  end
               endcase
            end
            if (cnt_ff[SlotW] && !rd_valid_ff) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_WRITE;
            rslot_in = '0;
            rpos_in = '0;
            case (func_type'(req_ff.func))
               FN_GET: begin
                  if (found_ff) begin
                     if (fmark_ff.lock || fmark_ff.refs >= RefLimit) begin
                        st_in = ST_BUSY; state_in = S_COUNT;
                     end else begin
                        st_in = ST_HIT; rslot_in = fslot_ff;
                        fmark_in.refs = fmark_ff.refs + 4'd1; fmark_in.lock = 1'b1;
                     end
                  end else if (ev_ff == '0) begin
                     st_in = ST_NOVICTIM; state_in = S_COUNT;
                  end else begin
                     st_in = ST_MISS;
                     rd_addr_in = hand_ff;
                     cnt_in = '0;
                     state_in = S_VICTIM;
                  end
               end
               FN_WB_TAKE: begin
                  if (found_ff) begin
                     st_in = ST_WBTAKEN; rslot_in = fslot_ff; rpos_in = fpos_ff;
                     fmark_in.refs = 4'd1; fmark_in.lock = 1'b1;
                  end else begin
                     st_in = ST_NONEDIRTY; state_in = S_COUNT;
                  end
               end
               FN_RELEASE: begin
                  if (fmark_ff.lock && fmark_ff.refs != 4'd0) begin
                     st_in = ST_HIT; rslot_in = fslot_ff;
                     fmark_in.dirty = fmark_ff.dirty | req_ff.mark_dirty;
                     fmark_in.lock = 1'b0; fmark_in.refs = fmark_ff.refs - 4'd1;
                  end else begin
                     st_in = ST_BADREL; state_in = S_COUNT;
                  end
               end
               default: begin
                  if (fmark_ff.lock && fmark_ff.dirty && fmark_ff.refs != 4'd0) begin
                     st_in = ST_HIT; rslot_in = fslot_ff;
                     fmark_in.dirty = 1'b0;
                     fmark_in.lock = 1'b0; fmark_in.refs = fmark_ff.refs - 4'd1;
                  end else begin
                     st_in = ST_BADREL; state_in = S_COUNT;
                  end
               end
            endcase
            if (state_in == S_COUNT) begin
               cnt_in = '0; rd_addr_in = '0; evn_in = '0; dtn_in = '0;
            end
         end
         S_VICTIM: begin
            if (!cnt_ff[SlotW] && !found_ff) begin
               cnt_in = cnt_ff + 1'b1;
               rd_addr_in = rd_addr_ff + 1'b1;
            end
            if (rd_valid_ff && !found_ff && evictable) begin
               found_in = 1'b1;
               fslot_in = rd_slot_ff;
               fmark_in = '{valid: 1'b1, refs: 4'd1, lock: 1'b1, dirty: 1'b0};
               hand_in = rd_slot_ff + 1'b1;
               rslot_in = rd_slot_ff;
               state_in = S_WRITE;
            end else if (cnt_ff[SlotW] && !rd_valid_ff) begin
               st_in = ST_NOVICTIM; rslot_in = '0;
               cnt_in = '0; rd_addr_in = '0; evn_in = '0; dtn_in = '0;
               state_in = S_COUNT;
            end
            if (state_in == S_VICTIM && found_ff) found_in = 1'b0;
         end
         S_WRITE: begin
            wr_en = 1'b1;
            wr_addr = fslot_ff;
            wr_mark = fmark_ff;
            wr_tag = (st_ff == ST_MISS);
            cnt_in = '0; rd_addr_in = '0; evn_in = '0; dtn_in = '0;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            if (!cnt_ff[SlotW]) begin
               cnt_in = cnt_ff + 1'b1;
               rd_addr_in = rd_addr_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               evn_in = evn_ff + CntW'(evictable);
               dtn_in = dtn_ff + CntW'(mark_rd_ff.dirty);
            end
            if (cnt_ff[SlotW] && !rd_valid_ff) begin
               ev_in = evn_ff; dt_in = dtn_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = st_ff;
               rsp_in.result_slot = rslot_ff;
               rsp_in.result_pos = rpos_ff;
               rsp_in.all_clean = (dtn_ff == '0);
               rsp_in.free_count = evn_ff;
               rsp_in.dirty_count = dtn_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

@@ sv/bcd_checker.sv @@
// Port checker for the block cache directory, bound to the top level.
// Depends on bcd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bcd_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input bcd_pkg::req_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input bcd_pkg::rsp_type rsp_data
);
   import bcd_pkg::*;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CHK_IMPLIES(a_clean_flag, clock, reset, rsp_valid,
      rsp_data.all_clean == (rsp_data.dirty_count == 7'd0))
   `CHK_IMPLIES(a_free_range, clock, reset, rsp_valid,
      rsp_data.free_count <= 7'(Slots) && rsp_data.dirty_count <= 7'(Slots))
   `CHK_NEXT(a_one_beat, clock, reset, req_valid && !req_stall, req_stall)
endmodule

bind block_cache_directory bcd_checker u_bcd_checker (.*);
